### rtl/pgd_pkg.sv
// pgd_pkg: shared widths, register codes and the beat type of the
// pixel gradient darken pipeline. No dependencies.
package pgd_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 6;
  localparam int CH_W       = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 7;
  localparam int POS_W      = 17;  // row*width + column
  localparam int N_W        = 18;  // width*height
  localparam int REM_W      = 26;  // channel * position * 2
  localparam int Q_W        = 10;  // saturated quotient bits
  localparam int DIV_W      = N_W + Q_W;
  localparam int DIV_STEPS  = Q_W / 2;
  localparam int LANES      = 3;   // red, green, blue
  localparam int STAGES     = 5 + DIV_STEPS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // floor(q/3) == (q*RECIP3) >> RECIP3_SH for every q below 2**Q_W
  localparam int RECIP3     = 683;
  localparam int RECIP3_SH  = 11;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_WIDTH  = 2'd0,
    CFG_AREA_HEIGHT = 2'd1,
    CFG_SOFT_MODE   = 2'd2
  } cfg_idx_t;

  // one pixel as it moves down the pipeline; lane 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [COL_W-1:0]                column;
    logic [ROW_W-1:0]                row;
    logic [LANES-1:0][CH_W-1:0]      chan;
    logic [CH_W-1:0]                 alpha;
    logic                            pass;   // empty area: no change
    logic                            clr;    // transparent pixel
    logic                            quarter; // soft mode: quarter-strength loss
    logic                            dbl;    // normal mode, red side
    logic [LANES-1:0]                act;    // lanes that get darkened
    logic [POS_W-1:0]                pos;
    logic [LANES-1:0][REM_W-1:0]     rem;
    logic [LANES-1:0]                sat;
    logic [LANES-1:0][Q_W-1:0]       quo;
  } pgd_beat_t;

endpackage

### rtl/pgd_in_if.sv
// pgd_in_if: input pixel channel, valid/ready with position and RGBA.
// Depends on pgd_pkg.
interface pgd_in_if;
  logic                          valid;
  logic                          ready;
  logic [pgd_pkg::COL_W-1:0]     column;
  logic [pgd_pkg::ROW_W-1:0]     row;
  logic [pgd_pkg::CH_W-1:0]      red_in;
  logic [pgd_pkg::CH_W-1:0]      green_in;
  logic [pgd_pkg::CH_W-1:0]      blue_in;
  logic [pgd_pkg::CH_W-1:0]      alpha_in;

  modport source (output valid, column, row, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink (input valid, column, row, red_in, green_in, blue_in, alpha_in,
                output ready);
endinterface

### rtl/pgd_out_if.sv
// pgd_out_if: result pixel channel, valid/ready with RGBA.
// Depends on pgd_pkg.
interface pgd_out_if;
  logic                          valid;
  logic                          ready;
  logic [pgd_pkg::CH_W-1:0]      red_out;
  logic [pgd_pkg::CH_W-1:0]      green_out;
  logic [pgd_pkg::CH_W-1:0]      blue_out;
  logic [pgd_pkg::CH_W-1:0]      alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out,
                output ready);
endinterface

### rtl/pgd_front.sv
// pgd_front: position multiply, channel products and divider setup
// (three register stages). Depends on pgd_pkg.
module pgd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [2:0]                        en,
  input  logic                              v_in,
  input  pgd_pkg::pgd_beat_t                d_in,
  input  logic [pgd_pkg::WIDTH_W-1:0]       area_width,
  input  logic [pgd_pkg::HEIGHT_W-1:0]      area_height,
  input  logic                              soft_mode,
  input  logic [pgd_pkg::N_W-1:0]           area_n,
  output logic [2:0]                        v_out,
  output pgd_pkg::pgd_beat_t                d_out
);
  import pgd_pkg::*;

  logic [2:0]  v_r;
  pgd_beat_t   s1_r, s1_nxt;
  pgd_beat_t   s2_r, s2_nxt;
  pgd_beat_t   s3_r, s3_nxt;
  logic        red_side;

  // stage 1: raster position and per-pixel decisions
  always_comb begin
    s1_nxt         = d_in;
    red_side       = d_in.chan[0] >= d_in.chan[2];
    s1_nxt.pos     = POS_W'(d_in.row) * POS_W'(area_width) + POS_W'(d_in.column);
    s1_nxt.pass    = (area_width == '0) || (area_height == '0);
    s1_nxt.clr     = d_in.alpha == '0;
    s1_nxt.quarter = soft_mode;
    s1_nxt.dbl     = !soft_mode && red_side;
    s1_nxt.act     = {!red_side, 1'b1, red_side};
  end

  // stage 2: channel times position, doubled on the normal red side
  always_comb begin
    s2_nxt = s1_r;
    for (int k = 0; k < LANES; k++) begin
      s2_nxt.rem[k] = (REM_W'(s1_r.chan[k]) * REM_W'(s1_r.pos)) << s1_r.dbl;
    end
  end

  // stage 3: quotients of 2**Q_W or more saturate
  always_comb begin
    s3_nxt     = s2_r;
    s3_nxt.quo = '0;
    for (int k = 0; k < LANES; k++) begin
      s3_nxt.sat[k] = DIV_W'(s2_r.rem[k]) >= {area_n, {Q_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= v_in;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
  end

  assign v_out = v_r;
  assign d_out = s3_r;
endmodule

### rtl/pgd_div_step.sv
// pgd_div_step: one restoring-division stage, two quotient bits per lane.
// Depends on pgd_pkg.
module pgd_div_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           v_in,
  input  pgd_pkg::pgd_beat_t             d_in,
  input  logic [pgd_pkg::DIV_W-1:0]      div_hi,
  input  logic [pgd_pkg::DIV_W-1:0]      div_lo,
  output logic                           v_out,
  output pgd_pkg::pgd_beat_t             d_out
);
  import pgd_pkg::*;

  logic       v_r;
  pgd_beat_t  d_r, d_nxt;

  // compare-subtract against divisor<<j, then divisor<<(j-1)
  always_comb begin
    logic [DIV_W-1:0] r;
    logic             bh, bl;
    d_nxt = d_in;
    for (int k = 0; k < LANES; k++) begin
      r  = DIV_W'(d_in.rem[k]);
      bh = r >= div_hi;
      if (bh) r = r - div_hi;
      bl = r >= div_lo;
      if (bl) r = r - div_lo;
      d_nxt.rem[k] = REM_W'(r);
      d_nxt.quo[k] = {d_in.quo[k][Q_W-3:0], bh, bl};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;
endmodule

### rtl/pgd_back.sv
// pgd_back: final scaling of the quotient, subtraction and output register.
// Depends on pgd_pkg.
module pgd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  pgd_pkg::pgd_beat_t     d_in,
  output logic                   v_out,
  output pgd_pkg::pgd_beat_t     d_out
);
  import pgd_pkg::*;

  logic       v_r;
  pgd_beat_t  d_r, d_nxt;

  always_comb begin
    logic [Q_W-1:0]          qs;
    logic [Q_W-1:0]          loss;
    logic [2*Q_W-1:0]        prod;
    d_nxt = d_in;
    for (int k = 0; k < LANES; k++) begin
      qs   = d_in.sat[k] ? {Q_W{1'b1}} : d_in.quo[k];
      prod = (2*Q_W)'(qs * (2*Q_W)'(RECIP3));
      if (d_in.quarter) begin
        loss = qs >> 2;
      end else if (d_in.dbl) begin
        loss = Q_W'(prod >> RECIP3_SH);
      end else begin
        loss = qs >> 1;
      end
      // loss at or above the channel value clips to zero
      if (d_in.pass) begin
        d_nxt.chan[k] = d_in.chan[k];
      end else if (d_in.clr) begin
        d_nxt.chan[k] = '0;
      end else if (d_in.act[k]) begin
        d_nxt.chan[k] = (loss >= Q_W'(d_in.chan[k])) ? '0
                        : CH_W'(Q_W'(d_in.chan[k]) - loss);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;
endmodule

### rtl/pixel_gradient_darken.sv
// pixel_gradient_darken: top level of the gradient darkening pipeline.
// Depends on pgd_pkg, pgd_in_if, pgd_out_if, pgd_front, pgd_div_step, pgd_back.
//
// Usage:
//   in_ch  : one pixel per beat (column, row, RGBA), valid/ready.
//   out_ch : one darkened RGBA pixel per input beat, same order, valid/ready.
//   cfg_*  : write port; index 0 area width, 1 area height, 2 soft mode.
//            Write only while the pipeline is empty.
//   Ten register stages: input register, position multiply, channel
//   products, saturation check, five stages of two quotient bits each, and
//   the output register. Throughput is one pixel per clock while out_ch.ready
//   stays high; the depth is set by the 10-bit restoring divider.
//   Each stage holds when the stage after it is full and stalled, so empty
//   stages keep filling while out_ch.ready is low; up to 10 beats sit in
//   the pipeline. Nothing is dropped or repeated on a stall.
//   Reset (rst_n low, synchronous) empties the pipeline and loads width
//   1024, height 64, soft mode 0.
module pixel_gradient_darken (
  input  logic                              clk,
  input  logic                              rst_n,
  pgd_in_if.sink                            in_ch,
  pgd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pgd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pgd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pgd_pkg::*;

  logic [WIDTH_W-1:0]   width_r;
  logic [HEIGHT_W-1:0]  height_r;
  logic                 soft_r;
  logic [N_W-1:0]       n_r;

  logic [STAGES-1:0]    v;
  logic [STAGES-1:0]    en;
  pgd_beat_t            d [STAGES];
  pgd_beat_t            d0_nxt;
  logic                 v0_r;
  pgd_beat_t            d0_r;

  // configuration registers; the area product is registered from them in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      soft_r   <= 1'b0;
      n_r      <= N_W'(WIDTH_RST) * N_W'(HEIGHT_RST);
    end else begin
      n_r <= N_W'(width_r) * N_W'(height_r);
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_AREA_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
          CFG_AREA_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
          CFG_SOFT_MODE:   soft_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // per-stage enable: a stage loads when empty or when the next one moves
  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ch.ready;
    for (int k = STAGES-2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  // stage 0: input register
  always_comb begin
    d0_nxt         = '0;
    d0_nxt.column  = in_ch.column;
    d0_nxt.row     = in_ch.row;
    d0_nxt.chan[0] = in_ch.red_in;
    d0_nxt.chan[1] = in_ch.green_in;
    d0_nxt.chan[2] = in_ch.blue_in;
    d0_nxt.alpha   = in_ch.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en[0]) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) d0_r <= d0_nxt;
  end

  assign v[0] = v0_r;
  assign d[0] = d0_r;

  pgd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en[3:1]),
    .v_in        (v[0]),
    .d_in        (d[0]),
    .area_width  (width_r),
    .area_height (height_r),
    .soft_mode   (soft_r),
    .area_n      (n_r),
    .v_out       (v[3:1]),
    .d_out       (d[3])
  );

  // quotient bits, most significant first
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [DIV_W-1:0] dhi, dlo;
    assign dhi = DIV_W'(n_r) << (Q_W - 1 - 2*s);
    assign dlo = DIV_W'(n_r) << (Q_W - 2 - 2*s);

    pgd_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en[4+s]),
      .v_in   (v[3+s]),
      .d_in   (d[3+s]),
      .div_hi (dhi),
      .div_lo (dlo),
      .v_out  (v[4+s]),
      .d_out  (d[4+s])
    );
  end

  pgd_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en[STAGES-1]),
    .v_in  (v[STAGES-2]),
    .d_in  (d[STAGES-2]),
    .v_out (v[STAGES-1]),
    .d_out (d[STAGES-1])
  );

  // unused intermediate slots: stages 1 and 2 live inside the front end
  assign d[1] = d[0];
  assign d[2] = d[0];

  assign out_ch.valid     = v[STAGES-1];
  assign out_ch.red_out   = d[STAGES-1].chan[0];
  assign out_ch.green_out = d[STAGES-1].chan[1];
  assign out_ch.blue_out  = d[STAGES-1].chan[2];
  assign out_ch.alpha_out = d[STAGES-1].alpha;
endmodule

### tb/tb_pixel_gradient_darken.sv
// tb_pixel_gradient_darken: self-checking bench for the gradient darken pipeline.
// Depends on pgd_pkg, pgd_in_if, pgd_out_if and pixel_gradient_darken.
// Pixels are driven in random bursts; results are checked against a local predictor.
module tb_pixel_gradient_darken;
  timeunit 1ns;
  timeprecision 1ps;
  import pgd_pkg::*;

  typedef struct {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [CH_W-1:0]  red, green, blue, alpha;
  } pixel_t;

  typedef struct {
    logic [CH_W-1:0] red, green, blue, alpha;
  } rgba_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pgd_in_if  in_if ();
  pgd_out_if out_if ();

  pixel_gradient_darken i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // local copy of the registers
  logic [WIDTH_W-1:0]  area_w = WIDTH_RST;
  logic [HEIGHT_W-1:0] area_h = HEIGHT_RST;
  logic                gentle = 1'b0;

  pixel_t pending_px[$];
  rgba_t  expected_px[$];
  pixel_t cur_px;
  int     errors = 0;
  int     cycles = 0;
  int     hold_reqs = 0;
  int     hold_done = 0;

  function automatic logic [CH_W-1:0] fade(longint unsigned c, longint unsigned num,
                                           longint unsigned den, longint unsigned div);
    longint unsigned loss;
    loss = ((c * num) / den) / div;
    return (loss >= c) ? '0 : CH_W'(c - loss);
  endfunction

  function automatic rgba_t darken(pixel_t px);
    rgba_t o;
    longint unsigned d, i;
    logic red_side;
    o = '{px.red, px.green, px.blue, px.alpha};
    d = 2 * longint'(area_w) * longint'(area_h);
    if (d == 0) return o;
    if (px.alpha == 0) begin
      o.red = '0; o.green = '0; o.blue = '0;
      return o;
    end
    i = 2 * (longint'(px.row) * longint'(area_w) + longint'(px.column));
    red_side = px.red >= px.blue;
    if (!gentle) begin
      if (red_side) begin
        o.red   = fade(px.red, 2 * i, d, 3);
        o.green = fade(px.green, 2 * i, d, 3);
      end else begin
        o.blue  = fade(px.blue, i, d, 2);
        o.green = fade(px.green, i, d, 2);
      end
    end else begin
      if (red_side) o.red = fade(px.red, i, d, 4);
      else o.blue = fade(px.blue, i, d, 4);
      o.green = fade(px.green, i, d, 4);
    end
    return o;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) expected_px = {expected_px, darken(cur_px)};
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          cur_px = pending_px.pop_front();
          in_if.valid    <= 1'b1;
          in_if.column   <= cur_px.column;
          in_if.row      <= cur_px.row;
          in_if.red_in   <= cur_px.red;
          in_if.green_in <= cur_px.green;
          in_if.blue_in  <= cur_px.blue;
          in_if.alpha_in <= cur_px.alpha;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall patterns; long hold on request
  int rx_mode = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (cycles % 32 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_cnt  <= 300;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0, 1: out_if.ready <= 1'b1;
        2: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result check and run limit
  always @(posedge clk) begin
    rgba_t e;
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb_pixel_gradient_darken: done, errors");
      $finish;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected beat %h %h %h %h", $realtime, out_if.red_out,
                 out_if.green_out, out_if.blue_out, out_if.alpha_out);
        errors <= errors + 1;
      end else begin
        e = expected_px.pop_front();
        if (e.red !== out_if.red_out || e.green !== out_if.green_out ||
            e.blue !== out_if.blue_out || e.alpha !== out_if.alpha_out) begin
          $display("%0t: mismatch exp rgba %h %h %h %h got %h %h %h %h", $realtime,
                   e.red, e.green, e.blue, e.alpha, out_if.red_out,
                   out_if.green_out, out_if.blue_out, out_if.alpha_out);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_area(int w, int h, int s);
    write_reg(CFG_AREA_WIDTH, w);
    write_reg(CFG_AREA_HEIGHT, h);
    write_reg(CFG_SOFT_MODE, s);
    area_w = WIDTH_W'(w);
    area_h = HEIGHT_W'(h);
    gentle = s[0];
  endtask

  task automatic add_px(int c, int r, int red, int g, int b, int a);
    pixel_t px;
    px = '{COL_W'(c), ROW_W'(r), CH_W'(red), CH_W'(g), CH_W'(b), CH_W'(a)};
    pending_px = {pending_px, px};
  endtask

  // random pixels, mostly inside the area, some anywhere
  task automatic add_random(int n);
    int cmax, rmax;
    cmax = (area_w == 0) ? 0 : ((area_w > 1024) ? 1023 : area_w - 1);
    rmax = (area_h == 0) ? 0 : ((area_h > 64) ? 63 : area_h - 1);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        add_px($urandom_range(0, 1023), $urandom_range(0, 63), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255),
               ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255));
      else
        add_px($urandom_range(0, cmax), $urandom_range(0, rmax), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255),
               ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255));
    end
  endtask

  // sender idles until every expected beat is back and the pipeline has emptied
  task automatic drain();
    while (pending_px.size() > 0 || in_if.valid || expected_px.size() > 0)
      @(posedge clk);
    repeat (STAGES + 2) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_if.valid = 1'b0; in_if.column = '0; in_if.row = '0;
    in_if.red_in = '0; in_if.green_in = '0; in_if.blue_in = '0; in_if.alpha_in = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset config: corners, alpha zero, both color branches
    add_px(0, 0, 255, 255, 255, 255);
    add_px(1023, 63, 255, 255, 255, 255);
    add_px(1023, 63, 10, 200, 255, 1);
    add_px(512, 32, 200, 100, 50, 128);
    add_px(512, 32, 50, 100, 200, 128);
    add_px(300, 20, 77, 77, 77, 9);
    add_px(700, 40, 255, 255, 255, 0);
    add_px(1, 0, 0, 0, 0, 255);
    add_px(1023, 63, 0, 255, 0, 255);
    drain();
    // soft mode, tiny area: out-of-area positions saturate
    set_area(1, 1, 1);
    add_px(0, 0, 255, 255, 255, 255);
    add_px(1023, 63, 255, 255, 255, 255);
    add_px(5, 1, 40, 90, 200, 3);
    add_px(0, 0, 0, 0, 0, 0);
    drain();
    set_area(1, 1, 0);
    add_px(0, 0, 255, 255, 1, 255);
    add_px(1023, 0, 3, 3, 9, 255);
    drain();
    // empty area: pixels pass unchanged, alpha zero included
    set_area(0, 5, 0);
    add_px(3, 2, 90, 80, 70, 0);
    add_px(1023, 63, 255, 255, 255, 255);
    add_random(40);
    drain();
    set_area(1024, 64, 1);
    add_px(1023, 63, 255, 255, 255, 255);
    add_random(200);
    hold_reqs++;
    drain();
    set_area(2047, 127, 0);
    add_random(100);
    drain();
    set_area(1024, 64, 0);
    add_random(300);
    hold_reqs++;
    drain();
    repeat (8) begin
      set_area($urandom_range(1, 1024), $urandom_range(1, 64), $urandom_range(0, 1));
      add_random(130);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0)
      $display("tb_pixel_gradient_darken: done, clean");
    else
      $display("tb_pixel_gradient_darken: done, errors");
    $finish;
  end
endmodule
